FILE: rtl/core/tpps_pkg.sv
// tpps_pkg: shared types, constants and the prescaler shift table
// for the timer prescaler period search block. No dependencies.
package tpps_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int TICKS_W       = 64;
  localparam int WHOLE_W       = TICKS_W - FRACTION_BITS;
  localparam int PERIOD_W      = 32;
  localparam int RATIO_W       = 9;
  localparam int CODE_W        = 3;
  localparam int SHIFT_W       = 4;
  localparam int LANES         = 8;
  localparam int LANES_TYPE0   = 4;
  localparam int OUT_TDATA_W   = 112;

  localparam logic [PERIOD_W-1:0] LIMIT_NARROW = 32'h0000_FFFF;
  localparam logic [PERIOD_W-1:0] LIMIT_WIDE   = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic CFG_TIMER_TYPE = 1'b0;
  localparam logic CFG_WIDE_MODE  = 1'b1;

  typedef struct packed {
    logic                act;
    logic [CODE_W-1:0]   code;
    logic [PERIOD_W-1:0] period;
    logic [RATIO_W-1:0]  ratio;
    logic [TICKS_W-1:0]  resid;
    logic                sat;
  } cand_t;

  // shift amount (log2 of prescaler) for a lane of the given timer type
  function automatic logic [SHIFT_W-1:0] lane_shift(input logic ttype,
                                                    input logic [CODE_W-1:0] lane);
    logic [SHIFT_W-1:0] sh;
    sh = '0;
    if (ttype) begin
      case (lane)
        3'd7:    sh = 4'd8;
        default: sh = {1'b0, lane};
      endcase
    end else begin
      case (lane)
        3'd0:    sh = 4'd0;
        3'd1:    sh = 4'd3;
        3'd2:    sh = 4'd6;
        3'd3:    sh = 4'd8;
        default: sh = 4'd0;
      endcase
    end
    return sh;
  endfunction

endpackage

FILE: rtl/core/tpps_pick.sv
// tpps_pick: one node of the candidate selection tree.
// Depends on tpps_pkg for the candidate struct.
module tpps_pick (
  input  tpps_pkg::cand_t lo_i,
  input  tpps_pkg::cand_t hi_i,
  output tpps_pkg::cand_t win_o
);

  // an active upper candidate wins over an inactive lower one, else only with a strictly smaller residual
  always_comb begin
    if (hi_i.act && (!lo_i.act || (hi_i.resid < lo_i.resid))) begin
      win_o = hi_i;
    end else begin
      win_o = lo_i;
    end
  end

endmodule

FILE: rtl/core/timer_prescaler_period_search.sv
// timer_prescaler_period_search: top level, five-stage pipeline.
// Depends on tpps_pkg and tpps_pick.
//
// One item per cycle sustained while out_tready stays high. Stage 0
// registers the target, stage 1 forms the period, clamp and residual of all
// eight prescaler lanes side by side, stages 2 to 4 form a registered
// three-level selection tree (lowest residual, ties to the smaller prescaler)
// whose last level is the output register. Each stage holds while the one
// after it is full and stalled, so out_tready low backs up to in_tready.
// Configuration must only be written while the pipeline is empty.
module timer_prescaler_period_search (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic                                 cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tpps_pkg::TICKS_W-1:0]         in_tdata,   // [63:0] target_ticks
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] prescaler_code, [34:3] period_count, [43:35] divide_ratio,
  // [107:44] residual_ticks, [108] period_saturated, [111:109] zero
  output logic [tpps_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic timer_type_r, wide_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_type_r <= 1'b0;
      wide_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpps_pkg::CFG_TIMER_TYPE: timer_type_r <= cfg_data;
        tpps_pkg::CFG_WIDE_MODE:  wide_mode_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [4:0] v_r;
  logic [4:0] rdy;

  assign rdy[4] = !v_r[4] || out_tready;
  assign rdy[3] = !v_r[3] || rdy[4];
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];
  assign in_tready = rdy[0];

  logic [4:0] v_nxt;
  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) v_nxt[0] = in_tvalid;
    if (rdy[1]) v_nxt[1] = v_r[0];
    if (rdy[2]) v_nxt[2] = v_r[1];
    if (rdy[3]) v_nxt[3] = v_r[2];
    if (rdy[4]) v_nxt[4] = v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 0: target register
  logic [tpps_pkg::TICKS_W-1:0] ticks_r;
  always_ff @(posedge clk) begin
    if (rdy[0]) ticks_r <= in_tdata;
  end

  // stage 1: per-lane period, clamp and residual
  tpps_pkg::cand_t lane_nxt [tpps_pkg::LANES];
  tpps_pkg::cand_t lane_r   [tpps_pkg::LANES];

  logic [tpps_pkg::WHOLE_W-1:0]  whole;
  logic [tpps_pkg::PERIOD_W-1:0] limit;
  assign whole = ticks_r[tpps_pkg::TICKS_W-1:tpps_pkg::FRACTION_BITS];
  assign limit = (timer_type_r && wide_mode_r) ? tpps_pkg::LIMIT_WIDE
                                               : tpps_pkg::LIMIT_NARROW;

  always_comb begin
    logic [tpps_pkg::SHIFT_W-1:0]  sh;
    logic [tpps_pkg::WHOLE_W-1:0]  pfull;
    logic [tpps_pkg::PERIOD_W-1:0] per;
    logic                          sat;
    logic [tpps_pkg::WHOLE_W-1:0]  used;
    for (int i = 0; i < tpps_pkg::LANES; i++) begin
      sh    = tpps_pkg::lane_shift(timer_type_r, tpps_pkg::CODE_W'(i));
      pfull = whole >> sh;
      sat   = pfull > tpps_pkg::WHOLE_W'(limit);
      per   = sat ? limit : pfull[tpps_pkg::PERIOD_W-1:0];
      used  = tpps_pkg::WHOLE_W'(per) << sh;
      lane_nxt[i].act    = timer_type_r || (i < tpps_pkg::LANES_TYPE0);
      lane_nxt[i].code   = tpps_pkg::CODE_W'(i);
      lane_nxt[i].period = per;
      lane_nxt[i].ratio  = tpps_pkg::RATIO_W'(1) << sh;
      // used has no fraction bits, so the fraction passes through
      lane_nxt[i].resid  = {whole - used, ticks_r[tpps_pkg::FRACTION_BITS-1:0]};
      lane_nxt[i].sat    = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) lane_r <= lane_nxt;
  end

  // stages 2 to 4: selection tree
  tpps_pkg::cand_t l2_nxt [4];
  tpps_pkg::cand_t l2_r   [4];
  tpps_pkg::cand_t l3_nxt [2];
  tpps_pkg::cand_t l3_r   [2];
  tpps_pkg::cand_t l4_nxt;
  tpps_pkg::cand_t l4_r;

  for (genvar g = 0; g < 4; g++) begin : g_l2
    tpps_pick u_pick (.lo_i(lane_r[2*g]), .hi_i(lane_r[2*g+1]), .win_o(l2_nxt[g]));
  end
  for (genvar g = 0; g < 2; g++) begin : g_l3
    tpps_pick u_pick (.lo_i(l2_r[2*g]), .hi_i(l2_r[2*g+1]), .win_o(l3_nxt[g]));
  end
  tpps_pick u_pick_l4 (.lo_i(l3_r[0]), .hi_i(l3_r[1]), .win_o(l4_nxt));

  always_ff @(posedge clk) begin
    if (rdy[2]) l2_r <= l2_nxt;
    if (rdy[3]) l3_r <= l3_nxt;
    if (rdy[4]) l4_r <= l4_nxt;
  end

  assign out_tvalid = v_r[4];
  assign out_tdata  = {3'b000, l4_r.sat, l4_r.resid, l4_r.ratio, l4_r.period, l4_r.code};

endmodule

FILE: tb/sv/tb_timer_prescaler_period_search.sv
// Testbench for timer_prescaler_period_search: drives target tick counts,
// predicts prescaler choice, period, residual and clamp, and checks each result.
// Depends on tpps_pkg and the block's RTL.
module tb_timer_prescaler_period_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [tpps_pkg::CODE_W-1:0]   code;
    logic [tpps_pkg::PERIOD_W-1:0] period;
    logic [tpps_pkg::RATIO_W-1:0]  ratio;
    logic [tpps_pkg::TICKS_W-1:0]  resid;
    logic                          sat;
  } choice_t;

  // log2 of the prescalers for each timer type
  localparam int TYPE0_SHIFT [4] = '{0, 3, 6, 8};
  localparam int TYPE1_SHIFT [8] = '{0, 1, 2, 3, 4, 5, 6, 8};

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic                             cfg_index;
  logic                             cfg_data;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [tpps_pkg::TICKS_W-1:0]     in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [tpps_pkg::OUT_TDATA_W-1:0] out_tdata;

  // local copy of the mode registers
  logic mode_timer_type;
  logic mode_wide;

  choice_t pending_choices[$];
  int      check_failures;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_requests;
  int      hold_off_served;
  int      hold_left;
  int      quiet_cycles;

  timer_prescaler_period_search uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic choice_t best_prescaler(input logic [tpps_pkg::TICKS_W-1:0] ticks);
    logic [tpps_pkg::WHOLE_W-1:0] whole;
    logic [tpps_pkg::WHOLE_W-1:0] limit;
    logic [tpps_pkg::WHOLE_W-1:0] per;
    logic [tpps_pkg::TICKS_W-1:0] rem;
    logic                         clamp;
    int                           n_cand;
    int                           sh;
    choice_t                      best;
    whole  = ticks[tpps_pkg::TICKS_W-1:tpps_pkg::FRACTION_BITS];
    n_cand = mode_timer_type ? 8 : 4;
    limit  = (mode_timer_type && mode_wide) ? tpps_pkg::WHOLE_W'(32'hFFFF_FFFF)
                                            : tpps_pkg::WHOLE_W'(16'hFFFF);
    best   = '0;
    for (int i = 0; i < n_cand; i++) begin
      sh    = mode_timer_type ? TYPE1_SHIFT[i] : TYPE0_SHIFT[i];
      per   = whole >> sh;
      clamp = per > limit;
      if (clamp) per = limit;
      rem = ticks - ((tpps_pkg::TICKS_W'(per) << sh) << tpps_pkg::FRACTION_BITS);
      if (i == 0 || rem < best.resid) begin
        best.code   = tpps_pkg::CODE_W'(i);
        best.period = tpps_pkg::PERIOD_W'(per);
        best.ratio  = tpps_pkg::RATIO_W'(1) << sh;
        best.resid  = rem;
        best.sat    = clamp;
      end
    end
    return best;
  endfunction

  // record a prediction for every accepted input item
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) pending_choices.push_back(best_prescaler(in_tdata));
  end

  always @(posedge clk) begin
    choice_t want;
    choice_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.code   = out_tdata[2:0];
      got.period = out_tdata[34:3];
      got.ratio  = out_tdata[43:35];
      got.resid  = out_tdata[107:44];
      got.sat    = out_tdata[108];
      if (pending_choices.size() == 0) begin
        $error("unexpected result item: tdata %h", out_tdata);
        check_failures++;
      end else begin
        want = pending_choices.pop_front();
        if (got.code !== want.code) begin
          $error("prescaler_code: expected %0d, actual %0d", want.code, got.code);
          check_failures++;
        end
        if (got.period !== want.period) begin
          $error("period_count: expected %0d, actual %0d", want.period, got.period);
          check_failures++;
        end
        if (got.ratio !== want.ratio) begin
          $error("divide_ratio: expected %0d, actual %0d", want.ratio, got.ratio);
          check_failures++;
        end
        if (got.resid !== want.resid) begin
          $error("residual_ticks: expected %h, actual %h", want.resid, got.resid);
          check_failures++;
        end
        if (got.sat !== want.sat) begin
          $error("period_saturated: expected %0d, actual %0d", want.sat, got.sat);
          check_failures++;
        end
      end
    end
  end

  // result side ready: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_off_requests != hold_off_served) begin
      hold_off_served <= hold_off_served + 1;
      hold_left       <= HOLD_OFF_LEN;
      out_tready      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_ticks(input logic [tpps_pkg::TICKS_W-1:0] ticks);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ticks;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wait until every predicted result has come back
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic timer_type, input logic wide);
    cfg_we    <= 1'b1;
    cfg_index <= tpps_pkg::CFG_TIMER_TYPE;
    cfg_data  <= timer_type;
    @(posedge clk);
    cfg_index <= tpps_pkg::CFG_WIDE_MODE;
    cfg_data  <= wide;
    @(posedge clk);
    cfg_we          <= 1'b0;
    mode_timer_type  = timer_type;
    mode_wide        = wide;
  endtask

  function automatic logic [tpps_pkg::TICKS_W-1:0] random_ticks;
    logic [tpps_pkg::TICKS_W-1:0] whole;
    logic [tpps_pkg::TICKS_W-1:0] frac;
    int                           sh;
    sh   = $urandom_range(0, 8);
    frac = $urandom_range(0, 1) ? tpps_pkg::TICKS_W'($urandom_range(0, 16'hFFFF)) : '0;
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} >> $urandom_range(0, 63);
      // exact multiples of a prescaler, with or without a fraction
      2: begin
        whole = (tpps_pkg::TICKS_W'($urandom) >> $urandom_range(0, 31)) << sh;
        return (whole << tpps_pkg::FRACTION_BITS) | frac;
      end
      // around the clamp point of one prescaler
      default: begin
        whole = (tpps_pkg::TICKS_W'($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'hFFFF) << sh)
                + tpps_pkg::TICKS_W'($urandom_range(0, 600)) - 64'd300;
        return (whole << tpps_pkg::FRACTION_BITS) | frac;
      end
    endcase
  endfunction

  task automatic test_directed_corners;
    logic [tpps_pkg::TICKS_W-1:0] corners[$];
    corners = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'hFFFF, 64'h1_0000, 64'h8_0000,
                64'h7_FFFF, 64'h100_0000, 64'hFFFF_0000, 64'h1_0000_0000,
                64'h00FF_FF00_0000, 64'h0100_0000_0000, 64'h8000_0000_0000_0000,
                64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corners[i]) send_ticks(corners[i]);
    drain();
  endtask

  task automatic test_wide_limit;
    logic [tpps_pkg::TICKS_W-1:0] corners[$];
    corners = '{64'hFFFF_FFFF_0000, 64'h1_0000_0000_0000, 64'hFF_FFFF_FF00_0000,
                64'h100_0000_0000_0000, 64'h0001_FFFE_0001_8000, 64'hFFFF_FFFF_FFFF_FFFF};
    set_mode(1'b1, 1'b1);
    foreach (corners[i]) send_ticks(corners[i]);
    drain();
  endtask

  task automatic test_random_phase(input logic timer_type, input logic wide,
                                   input int idle_pct, input int stall_pct, input int n_items);
    set_mode(timer_type, wide);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_ticks(random_ticks());
    drain();
  endtask

  // long result stall while items keep coming, so the input backs up
  task automatic test_backpressure;
    set_mode(1'b1, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_requests++;
    repeat (60) send_ticks(random_ticks());
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = tpps_pkg::CFG_TIMER_TYPE;
    cfg_data          = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    out_tready        = 1'b0;
    mode_timer_type   = 1'b0;
    mode_wide         = 1'b0;
    check_failures    = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_off_requests = 0;
    hold_off_served   = 0;
    hold_left         = 0;
    quiet_cycles      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_wide_limit();
    test_random_phase(1'b0, 1'b0,  0,  0, 200);
    test_random_phase(1'b1, 1'b0, 79,  0, 200);
    test_random_phase(1'b1, 1'b1,  0, 79, 200);
    test_random_phase(1'b0, 1'b1, 10, 10, 200);
    test_random_phase(1'b1, 1'b1,  0,  0, 200);
    test_random_phase(1'b0, 1'b0,  0, 79, 150);
    test_random_phase(1'b1, 1'b0, 10, 10, 200);
    test_random_phase(1'b1, 1'b1, 79,  0, 150);
    test_backpressure();
    test_random_phase(1'b0, 1'b0, 10, 10, 50);

    if (check_failures == 0 && pending_choices.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tpps_pkg.sv
rtl/core/tpps_pick.sv
rtl/core/timer_prescaler_period_search.sv
tb/sv/tb_timer_prescaler_period_search.sv
